// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/kti_pkg.sv =====
// shared types and constants of the keyframe track interpolator
// no dependencies
`default_nettype none

package kti_pkg;

   localparam int DATA_W              = 32;
   localparam int INDEX_W             = 12;
   localparam int FRAC_W              = 14;
   localparam int FRAC_SHIFT          = 12;
   localparam int CSR_INDEX_W         = 3;
   localparam int CSR_DATA_W          = 13;
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   typedef logic [DATA_W-1:0]      word_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   localparam csr_index_type CSR_DECIMATION    = 3'd0;
   localparam csr_index_type CSR_INTERP_LIMIT  = 3'd1;
   localparam csr_index_type CSR_NARROW_VALUES = 3'd2;
   localparam csr_index_type CSR_FRAME_COUNT   = 3'd3;
   localparam csr_index_type CSR_WRAP_TO_FIRST = 3'd4;

endpackage

`default_nettype wire

// ===== src/kti_key_mem.sv =====
// key table: one write port, two registered read ports
// depends on kti_pkg
`default_nettype none

module kti_key_mem #(
   parameter int DEPTH = kti_pkg::DEFAULT_TABLE_DEPTH,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  kti_pkg::word_type  wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr_a,
   input  logic [AW-1:0]      rd_addr_b,
   output kti_pkg::word_type  rd_data_a,
   output kti_pkg::word_type  rd_data_b
);

   kti_pkg::word_type mem [DEPTH];
   kti_pkg::word_type rd_data_a_ff;
   kti_pkg::word_type rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem[rd_addr_a];
         rd_data_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ===== src/keyframe_track_interpolator.sv =====
// top level of the keyframe track interpolator
// depends on kti_pkg, kti_key_mem and assert_macros.svh
`default_nettype none

// usage
//   req channel: a word is taken at a rising edge with start high and busy low.
//   req_type selects a table write (entry_index, entry_value) or a sample at
//   req_frame_pos, an unsigned 10.12 frame position.
//   rsp channel: one word per sample, on rsp_sample_value for exactly one
//   cycle with rsp_valid high; writes give no rsp word.
//   csr port: csr_we writes register csr_index with csr_wdata at the edge;
//   change registers only while no word is in flight.
//   pipeline: a sample taken passes the stage registers p1 to p5, with the key
//   table's read register between p2 and p4, and then the rsp register.
//   throughput: one word per cycle while busy is low; the two-read, one-write key
//   table port and the single diff-times-fraction multiplier are each used once a word.
//   a write is visible to any word taken after it.
//   reset: busy is high while reset is high; the pipeline empties and the
//   registers return to their reset values. the table is not cleared.
//   the receiver cannot stall, so start is never held off after reset.

`include "assert_macros.svh"

module keyframe_track_interpolator #(
   parameter int TABLE_DEPTH = kti_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [9:0]                         req_entry_index,
   input  logic signed [31:0]                 req_entry_value,
   input  logic [21:0]                        req_frame_pos,
   output logic                               rsp_valid,
   output logic signed [31:0]                 rsp_sample_value,
   input  logic                               csr_we,
   input  logic [kti_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kti_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int XW        = kti_pkg::INDEX_W;
   localparam int FW        = kti_pkg::FRAC_W;
   localparam int MOD_SHIFT = 24;
   localparam int MW        = XW + 18;
   localparam logic [MOD_SHIFT-1:0] MOD_MULT =
      MOD_SHIFT'((64'd1 << MOD_SHIFT) / TABLE_DEPTH);
   localparam logic [MW-1:0] DEPTH_W = MW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   // configuration registers
   logic [1:0]  decimation_ff;
   logic [12:0] interp_limit_ff;
   logic        narrow_values_ff;
   logic [10:0] frame_count_ff;
   logic        wrap_to_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decimation_ff    <= 2'd0;
         interp_limit_ff  <= 13'd0;
         narrow_values_ff <= 1'b0;
         frame_count_ff   <= 11'd1;
         wrap_to_first_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            kti_pkg::CSR_DECIMATION:    decimation_ff    <= csr_wdata[1:0];
            kti_pkg::CSR_INTERP_LIMIT:  interp_limit_ff  <= csr_wdata[12:0];
            kti_pkg::CSR_NARROW_VALUES: narrow_values_ff <= csr_wdata[0];
            kti_pkg::CSR_FRAME_COUNT:   frame_count_ff   <= csr_wdata[10:0];
            kti_pkg::CSR_WRAP_TO_FIRST: wrap_to_first_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // word decode: key index, fraction and scale shift
   logic [XW-1:0] x_in;
   logic [FW-1:0] frac_in;
   logic [1:0]    sh_in;
   logic          last_in;

   always_comb begin
      logic [9:0]    frame;
      logic          below;
      logic          half;
      logic          quarter;
      logic [XW-1:0] idx;
      frame   = req_frame_pos[21:12];
      below   = {3'b000, frame} < interp_limit_ff;
      half    = decimation_ff[0];
      quarter = (decimation_ff == 2'b10);
      last_in = (11'(frame) + 11'd1) == frame_count_ff;
      idx     = XW'(frame);
      frac_in = FW'(req_frame_pos[11:0]);
      sh_in   = 2'd0;
      if (last_in) begin
         if (half) begin
            idx = XW'(frame[9:1]) + XW'(frame[0]);
         end else if (quarter) begin
            idx = XW'(frame[9:2]) + XW'(frame[1:0]);
         end
         if (!wrap_to_first_ff) begin
            frac_in = '0;
         end
      end else if (half) begin
         if (below) begin
            idx     = XW'(frame[9:1]);
            frac_in = FW'(req_frame_pos[12:0]);
            sh_in   = 2'd1;
         end else begin
            idx = XW'(interp_limit_ff[12:1]);
         end
      end else if (quarter) begin
         if (below) begin
            idx     = XW'(frame[9:2]);
            frac_in = req_frame_pos[13:0];
            sh_in   = 2'd2;
         end else begin
            idx = XW'(frame[9:2]) + XW'(frame[1:0]);
         end
      end
      x_in = (req_type == kti_pkg::REQ_SAMPLE) ? idx : XW'(req_entry_index);
   end

   // pipeline registers
   logic                 p1_valid_ff, p2_valid_ff, p3_valid_ff, p4_valid_ff, p5_valid_ff;
   logic                 p1_sample_ff, p2_sample_ff, p3_sample_ff, p4_sample_ff, p5_sample_ff;
   logic                 p1_last_ff, p2_last_ff;
   logic [FW-1:0]        p1_frac_ff, p2_frac_ff, p3_frac_ff, p4_frac_ff;
   logic [1:0]           p1_sh_ff, p2_sh_ff, p3_sh_ff, p4_sh_ff, p5_sh_ff;
   logic [XW-1:0]        p1_x_ff, p2_x_ff;
   logic [XW-1:0]        p2_q_ff;
   kti_pkg::word_type    p1_value_ff, p2_value_ff;
   kti_pkg::word_type    p4_diff_ff, p4_v0_ff, p5_v0_ff, p5_prod_ff;
   kti_pkg::word_type    rsp_value_ff;
   logic                 rsp_valid_ff;

   // table address modulo the depth: reciprocal multiply, then one correction
   logic [XW+MOD_SHIFT-1:0] mod_prod;
   logic [MW-1:0]           rem_raw;
   logic [MW-1:0]           rem;
   logic [AW-1:0]           rd_addr_a;
   logic [AW-1:0]           rd_addr_b;

   assign mod_prod = {{MOD_SHIFT{1'b0}}, p1_x_ff} * {{XW{1'b0}}, MOD_MULT};
   assign rem_raw  = MW'(p2_x_ff) - (MW'(p2_q_ff) * DEPTH_W);
   assign rem      = (rem_raw >= DEPTH_W) ? (rem_raw - DEPTH_W) : rem_raw;
   assign rd_addr_a = rem[AW-1:0];
   assign rd_addr_b = p2_last_ff ? '0 : ((rd_addr_a == LAST_ADDR) ? '0 : rd_addr_a + AW'(1));

   kti_pkg::word_type rd_data_a;
   kti_pkg::word_type rd_data_b;

   kti_key_mem #(
      .DEPTH (TABLE_DEPTH)
   ) u_key_mem (
      .clock     (clock),
      .wr_en     (p2_valid_ff && (p2_sample_ff == kti_pkg::REQ_WRITE)),
      .wr_addr   (rd_addr_a),
      .wr_data   (p2_value_ff),
      .rd_en     (p2_valid_ff && (p2_sample_ff == kti_pkg::REQ_SAMPLE)),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // narrow entries are sign-extended from 16 bits
   kti_pkg::word_type v0;
   kti_pkg::word_type v1;
   assign v0 = narrow_values_ff ? {{16{rd_data_a[15]}}, rd_data_a[15:0]} : rd_data_a;
   assign v1 = narrow_values_ff ? {{16{rd_data_b[15]}}, rd_data_b[15:0]} : rd_data_b;

   logic [kti_pkg::DATA_W+FW-1:0] mul_full;
   assign mul_full = {{FW{1'b0}}, p4_diff_ff} * {{kti_pkg::DATA_W{1'b0}}, p4_frac_ff};

   kti_pkg::word_type step_term;
   kti_pkg::word_type scaled_sum;
   kti_pkg::word_type result_in;
   assign step_term  = kti_pkg::word_type'($signed(p5_prod_ff) >>> kti_pkg::FRAC_SHIFT);
   assign scaled_sum = (p5_v0_ff << p5_sh_ff) + step_term;
   assign result_in  = kti_pkg::word_type'($signed(scaled_sum) >>> p5_sh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         p5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= accept;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff && (p2_sample_ff == kti_pkg::REQ_SAMPLE);
         p4_valid_ff  <= p3_valid_ff;
         p5_valid_ff  <= p4_valid_ff;
         rsp_valid_ff <= p5_valid_ff && (p5_sample_ff == kti_pkg::REQ_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      p1_sample_ff <= req_type;
      p1_last_ff   <= last_in;
      p1_frac_ff   <= frac_in;
      p1_sh_ff     <= sh_in;
      p1_x_ff      <= x_in;
      p1_value_ff  <= req_entry_value;

      p2_sample_ff <= p1_sample_ff;
      p2_last_ff   <= p1_last_ff;
      p2_frac_ff   <= p1_frac_ff;
      p2_sh_ff     <= p1_sh_ff;
      p2_x_ff      <= p1_x_ff;
      p2_q_ff      <= mod_prod[XW+MOD_SHIFT-1:MOD_SHIFT];
      p2_value_ff  <= p1_value_ff;

      p3_sample_ff <= p2_sample_ff;
      p3_frac_ff   <= p2_frac_ff;
      p3_sh_ff     <= p2_sh_ff;

      p4_sample_ff <= p3_sample_ff;
      p4_frac_ff   <= p3_frac_ff;
      p4_sh_ff     <= p3_sh_ff;
      p4_diff_ff   <= v1 - v0;
      p4_v0_ff     <= v0;

      p5_sample_ff <= p4_sample_ff;
      p5_sh_ff     <= p4_sh_ff;
      p5_v0_ff     <= p4_v0_ff;
      p5_prod_ff   <= mul_full[kti_pkg::DATA_W-1:0];

      rsp_value_ff <= result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = $signed(rsp_value_ff);

   `ASSERT_NEXT(a_accept_enters_pipe, clock, reset, accept, p1_valid_ff)
   `ASSERT_NEXT(a_sample_gives_word, clock, reset, p5_valid_ff && p5_sample_ff, rsp_valid)
   `ASSERT_NEXT(a_idle_gives_no_word, clock, reset, !p5_valid_ff, !rsp_valid)
   `ASSERT_ALWAYS(a_addr_in_range, clock, reset, !p2_valid_ff || ((32'(rd_addr_a) < 32'(TABLE_DEPTH)) && (32'(rd_addr_b) < 32'(TABLE_DEPTH))))

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for keyframe_track_interpolator: directed and random table writes and samples,
// checked word by word by a scoreboard class that predicts each interpolated value
// depends on kti_pkg and the rtl under src
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = kti_pkg::DEFAULT_TABLE_DEPTH;
   localparam int PHASES       = 16;
   localparam int PHASE_WORDS  = 90;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      logic              kind;
      logic [9:0]        index;
      kti_pkg::word_type value;
      logic [21:0]       pos;
   } key_word_type;

   class sample_scoreboard;
      kti_pkg::word_type keys[DEPTH];
      logic [1:0]        decimation;
      logic [12:0]       interp_limit;
      logic              narrow;
      logic [10:0]       frame_count;
      logic              wrap_first;
      kti_pkg::word_type expected_q[$];
      int                errors;

      function new();
         decimation   = 0;
         interp_limit = 0;
         narrow       = 0;
         frame_count  = 1;
         wrap_first   = 0;
         errors       = 0;
      endfunction

      function void set_register(kti_pkg::csr_index_type idx, logic [12:0] data);
         case (idx)
            kti_pkg::CSR_DECIMATION:    decimation   = data[1:0];
            kti_pkg::CSR_INTERP_LIMIT:  interp_limit = data;
            kti_pkg::CSR_NARROW_VALUES: narrow       = data[0];
            kti_pkg::CSR_FRAME_COUNT:   frame_count  = data[10:0];
            kti_pkg::CSR_WRAP_TO_FIRST: wrap_first   = data[0];
            default: ;
         endcase
      endfunction

      function kti_pkg::word_type read_key(int i);
         kti_pkg::word_type e;
         e = keys[i % DEPTH];
         if (narrow) return {{16{e[15]}}, e[15:0]};
         return e;
      endfunction

      function bit last_frame(logic [21:0] pos);
         return frame_count != 0 && int'(pos[21:12]) == int'(frame_count) - 1;
      endfunction

      function int base_entry(logic [21:0] pos);
         int frame;
         bit half, quarter;
         frame   = pos[21:12];
         half    = decimation[0];
         quarter = !half && decimation[1];
         if (last_frame(pos)) begin
            if (half) return (frame >> 1) + (frame & 1);
            if (quarter) return (frame >> 2) + (frame & 3);
            return frame;
         end
         if (half) return (frame >= interp_limit) ? int'(interp_limit >> 1) : frame >> 1;
         if (quarter) return (frame >= interp_limit) ? (frame >> 2) + (frame & 3) : frame >> 2;
         return frame;
      endfunction

      function kti_pkg::word_type scaled_diff(kti_pkg::word_type lo, kti_pkg::word_type hi,
                                              logic [31:0] frac);
         kti_pkg::word_type prod;
         prod = (hi - lo) * frac;
         return $signed(prod) >>> kti_pkg::FRAC_SHIFT;
      endfunction

      function kti_pkg::word_type interpolate(logic [21:0] pos);
         int                idx;
         int                step_log;
         logic [31:0]       frac;
         kti_pkg::word_type v0, v1, acc;
         idx = base_entry(pos);
         v0  = read_key(idx);
         if (last_frame(pos)) begin
            if (!wrap_first) return v0;
            return v0 + scaled_diff(v0, read_key(0), 32'(pos[11:0]));
         end
         step_log = 0;
         frac     = 32'(pos[11:0]);
         if (int'(pos[21:12]) < int'(interp_limit)) begin
            if (decimation[0]) begin
               step_log = 1;
               frac     = 32'(pos[12:0]);
            end else if (decimation[1]) begin
               step_log = 2;
               frac     = 32'(pos[13:0]);
            end
         end
         v1  = read_key(idx + 1);
         acc = (v0 << step_log) + scaled_diff(v0, v1, frac);
         return $signed(acc) >>> step_log;
      endfunction

      function void note_word(key_word_type w);
         if (w.kind == kti_pkg::REQ_WRITE) keys[w.index % DEPTH] = w.value;
         else expected_q.push_back(interpolate(w.pos));
      endfunction

      function void check_result(kti_pkg::word_type got);
         kti_pkg::word_type want;
         if (expected_q.size() == 0) begin
            $error("sample_value with no word pending: actual %h", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got !== want) begin
            $error("sample_value mismatch: expected %h, actual %h", want, got);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic                           req_type = kti_pkg::REQ_WRITE;
   logic [9:0]                     req_entry_index = '0;
   logic signed [31:0]             req_entry_value = '0;
   logic [21:0]                    req_frame_pos = '0;
   logic                           rsp_valid;
   logic signed [31:0]             rsp_sample_value;
   logic                           csr_we = 1'b0;
   kti_pkg::csr_index_type         csr_index = kti_pkg::CSR_DECIMATION;
   logic [kti_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   sample_scoreboard sb = new();
   bit               key_written[DEPTH];
   bit               gaps_on = 1'b0;
   int               cycles = 0;

   keyframe_track_interpolator #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_entry_index  (req_entry_index),
      .req_entry_value  (req_entry_value),
      .req_frame_pos    (req_frame_pos),
      .rsp_valid        (rsp_valid),
      .rsp_sample_value (rsp_sample_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            sb.check_result(rsp_sample_value);
         end else if (rsp_valid !== 1'b0) begin
            $error("rsp_valid unknown");
            sb.errors++;
         end
      end
   end

   task automatic send_word(input key_word_type w);
      @(negedge clock);
      start           <= 1'b1;
      req_type        <= w.kind;
      req_entry_index <= w.index;
      req_entry_value <= w.value;
      req_frame_pos   <= w.pos;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_word(w);
      if (w.kind == kti_pkg::REQ_WRITE) key_written[w.index % DEPTH] = 1'b1;
   endtask

   task automatic pause(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic random_gap();
      if (gaps_on && $urandom_range(0, 2) == 0)
         pause(($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3));
   endtask

   function automatic kti_pkg::word_type pick_value();
      case ($urandom_range(0, 15))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return ($urandom_range(0, 1) != 0) ? 32'h0000_7fff : 32'h0000_8000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [21:0] pick_pos();
      int frame;
      case ($urandom_range(0, 6))
         0: frame = int'(sb.frame_count) - 1;
         1: frame = int'(sb.interp_limit) + int'($urandom_range(0, 3)) - 2;
         default: frame = $urandom_range(0, DEPTH - 1);
      endcase
      if (frame < 0 || frame > DEPTH - 1) frame = $urandom_range(0, DEPTH - 1);
      return {frame[9:0], 12'($urandom)};
   endfunction

   task automatic write_key(input int index, input kti_pkg::word_type value);
      key_word_type w;
      w.kind  = kti_pkg::REQ_WRITE;
      w.index = 10'(index);
      w.value = value;
      w.pos   = 22'($urandom);
      send_word(w);
   endtask

   // keys the sample will read are loaded first
   task automatic sample_at(input logic [21:0] pos);
      key_word_type w;
      int           idx;
      idx = sb.base_entry(pos) % DEPTH;
      if (!key_written[idx]) write_key(idx, pick_value());
      if (!key_written[(idx + 1) % DEPTH]) write_key((idx + 1) % DEPTH, pick_value());
      if (!key_written[0]) write_key(0, pick_value());
      w.kind  = kti_pkg::REQ_SAMPLE;
      w.index = 10'($urandom);
      w.value = $urandom;
      w.pos   = pos;
      send_word(w);
   endtask

   task automatic write_register(input kti_pkg::csr_index_type idx, input logic [12:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.set_register(idx, data);
   endtask

   task automatic apply_settings(input logic [1:0] dec, input logic [12:0] lim,
                                 input logic nar, input logic [10:0] fc, input logic wrap);
      pause(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_register(kti_pkg::CSR_DECIMATION, 13'(dec));
      write_register(kti_pkg::CSR_INTERP_LIMIT, lim);
      write_register(kti_pkg::CSR_NARROW_VALUES, 13'(nar));
      write_register(kti_pkg::CSR_FRAME_COUNT, 13'(fc));
      write_register(kti_pkg::CSR_WRAP_TO_FIRST, 13'(wrap));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int          phase;
      logic [10:0] fc;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full rate, last frame wraps toward entry zero
      apply_settings(2'd0, 13'd0, 1'b0, 11'd1024, 1'b1);
      write_key(0, 32'h7fff_ffff);
      write_key(1, 32'h8000_0000);
      write_key(1023, 32'hffff_ffff);
      write_key(2, 32'h0000_0000);
      sample_at(22'h000000);
      sample_at(22'h000fff);
      sample_at(22'h001800);
      sample_at(22'h3ff000);
      sample_at(22'h3fffff);
      // decimation code three, narrow entries, no last frame
      apply_settings(2'd3, 13'd8191, 1'b1, 11'd0, 1'b0);
      write_key(3, 32'h1234_8000);
      write_key(4, 32'hffff_7fff);
      sample_at(22'h007fff);
      sample_at(22'h000abc);
      // next entry wraps past the table end
      apply_settings(2'd0, 13'd0, 1'b0, 11'd0, 1'b1);
      sample_at(22'h3ff800);
      // quarter rate on both sides of the limit
      apply_settings(2'd2, 13'd12, 1'b0, 11'd2047, 1'b0);
      sample_at(22'h00ffff);
      sample_at(22'h002fff);
      // half rate on both sides of the limit and at the last frame
      apply_settings(2'd1, 13'd5, 1'b0, 11'd9, 1'b1);
      sample_at(22'h008fff);
      sample_at(22'h007abc);
      sample_at(22'h003fff);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: apply_settings(2'd0, 13'd0, 1'b0, 11'd1, 1'b0);
            1: apply_settings(2'd1, 13'd8191, 1'b0, 11'd1024, 1'b1);
            2: apply_settings(2'd2, 13'd8191, 1'b1, 11'd1024, 1'b0);
            3: apply_settings(2'd3, 13'd100, 1'b0, 11'd512, 1'b1);
            4: apply_settings(2'd2, 13'd0, 1'b0, 11'd2047, 1'b1);
            5: apply_settings(2'd1, 13'd0, 1'b1, 11'd0, 1'b0);
            default: begin
               case ($urandom_range(0, 5))
                  0: fc = 11'd0;
                  1: fc = 11'd2047;
                  2: fc = 11'($urandom_range(1, 16));
                  default: fc = 11'($urandom_range(1, 1024));
               endcase
               apply_settings(2'($urandom_range(0, 3)),
                              ($urandom_range(0, 4) == 0) ? 13'd8191 : 13'($urandom_range(0, 1100)),
                              1'($urandom), fc, 1'($urandom));
            end
         endcase
         gaps_on = (phase % 3 != 0);
         repeat (PHASE_WORDS) begin
            if ($urandom_range(0, 3) == 0) write_key($urandom_range(0, DEPTH - 1), pick_value());
            else sample_at(pick_pos());
            random_gap();
         end
      end

      pause(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+src
src/kti_pkg.sv
src/kti_key_mem.sv
src/keyframe_track_interpolator.sv
tb/testbench.sv
